/* rtl/pgek_pkg.sv */
// Package for the per-group earliest-k buffer.
// Shared constants and controller/datapath command and status types.
// No dependencies.
package pgek_pkg;

   localparam int STORE_SLOTS_DEF = 256;
   localparam int PANEL_COUNT_DEF = 256;
   localparam int PANEL_W         = 8;
   localparam int TDC_W           = 16;
   localparam int TAG_W           = 16;
   localparam int ORDER_W         = 16;
   localparam int KEEP_W          = 9;
   localparam logic [KEEP_W-1:0] KEEP_RESET = 9'd16;

   localparam logic [1:0] ACT_PUSH  = 2'd0;
   localparam logic [1:0] ACT_POP   = 2'd1;
   localparam logic [1:0] ACT_CLEAR = 2'd2;

   typedef struct packed {
      logic start;        // latch request, reset scan candidates
      logic rd_en;        // read slot at scan address
      logic finish_push;  // commit push decision
      logic finish_pop;   // load result, free popped slot
      logic do_clear;     // empty the store
   } cmd_type;

   typedef struct packed {
      logic rsp_busy;     // result register still holds an untaken result
   } status_type;

endpackage

/* rtl/pgek_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module pgek_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* rtl/pgek_ctrl.sv */
// Controller: sequences the slot scan for push and pop requests.
// Depends on pgek_pkg.
module pgek_ctrl #(
   parameter int STORE_SLOTS = pgek_pkg::STORE_SLOTS_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic [1:0]                     req_action,
   input  pgek_pkg::status_type           status,
   output pgek_pkg::cmd_type              cmd,
   output logic [$clog2(STORE_SLOTS)-1:0] scan_addr
);

   localparam int AW = $clog2(STORE_SLOTS);
   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_SCAN  = 2'd1;
   localparam logic [1:0] ST_FLUSH = 2'd2;
   localparam logic [1:0] ST_FIN   = 2'd3;

   logic [1:0]    state_ff, state_in;
   logic [AW-1:0] cnt_ff, cnt_in;
   logic          pop_ff, pop_in;

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      pop_in   = pop_ff;
      cmd      = '0;
      req_ready = (state_ff == ST_IDLE);
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               case (req_action)
                  pgek_pkg::ACT_PUSH, pgek_pkg::ACT_POP: begin
                     cmd.start = 1'b1;
                     pop_in    = (req_action == pgek_pkg::ACT_POP);
                     cnt_in    = '0;
                     state_in  = ST_SCAN;
                  end
                  pgek_pkg::ACT_CLEAR: cmd.do_clear = 1'b1;
                  default: ;
               endcase
            end
         end
         ST_SCAN: begin
            cmd.rd_en = 1'b1;
            cnt_in    = cnt_ff + 1'b1;
            if (cnt_ff == AW'(STORE_SLOTS - 1)) begin
               state_in = ST_FLUSH;
            end
         end
         ST_FLUSH: state_in = ST_FIN;
         ST_FIN: begin
            if (!pop_ff) begin
               cmd.finish_push = 1'b1;
               state_in = ST_IDLE;
            end else if (!status.rsp_busy) begin
               cmd.finish_pop = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff   <= '0;
         pop_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         pop_ff   <= pop_in;
      end
   end

   assign scan_addr = cnt_ff;

endmodule

/* rtl/pgek_datapath.sv */
// Datapath: slot RAM, used bits, scan candidates, counters and result register.
// Depends on pgek_pkg and pgek_ram.
module pgek_datapath #(
   parameter int STORE_SLOTS = pgek_pkg::STORE_SLOTS_DEF,
   parameter int PANEL_COUNT = pgek_pkg::PANEL_COUNT_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  pgek_pkg::cmd_type                   cmd,
   output pgek_pkg::status_type                status,
   input  logic [$clog2(STORE_SLOTS)-1:0]      scan_addr,
   input  logic [pgek_pkg::PANEL_W-1:0]        req_panel_id,
   input  logic [pgek_pkg::TDC_W-1:0]          req_tdc,
   input  logic [pgek_pkg::TAG_W-1:0]          req_hit_index,
   input  logic                                req_is_pop,
   input  logic                                csr_wr_en,
   input  logic [pgek_pkg::KEEP_W-1:0]         csr_wr_data,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic                                rsp_valid_res,
   output logic [pgek_pkg::PANEL_W-1:0]        rsp_out_panel,
   output logic [pgek_pkg::TDC_W-1:0]          rsp_out_tdc,
   output logic [pgek_pkg::TAG_W-1:0]          rsp_out_index,
   output logic                                rsp_last,
   output logic                                rsp_overflowed
);

   localparam int AW = $clog2(STORE_SLOTS);
   localparam int CW = $clog2(STORE_SLOTS + 1);
   localparam int PW = pgek_pkg::PANEL_W;
   localparam int TW = pgek_pkg::TDC_W;
   localparam int GW = pgek_pkg::TAG_W;
   localparam int OW = pgek_pkg::ORDER_W;
   localparam int DW = TW + PW + GW + OW;

   logic [pgek_pkg::KEEP_W-1:0] keep_ff;
   logic [PW-1:0] panel_ff;
   logic [TW-1:0] tdc_ff;
   logic [GW-1:0] tag_ff;
   logic [OW-1:0] arrival_ff;
   logic          overflow_ff;
   logic [STORE_SLOTS-1:0] used_ff;

   logic          rd_vld_ff;
   logic [AW-1:0] rd_idx_ff;
   logic [DW-1:0] rd_data;

   logic          have_free_ff, have_best_ff;
   logic [AW-1:0] free_ff, best_ff;
   logic [TW-1:0] best_tdc_ff;
   logic [OW-1:0] best_age_ff;
   logic [PW-1:0] best_panel_ff;
   logic [GW-1:0] best_tag_ff;
   logic [CW-1:0] count_ff;
   logic          pop_ff;

   logic          rsp_valid_ff, rsp_valid_res_ff, rsp_last_ff, rsp_overflowed_ff;
   logic [PW-1:0] rsp_panel_ff;
   logic [TW-1:0] rsp_tdc_ff;
   logic [GW-1:0] rsp_index_ff;

   logic [TW-1:0] s_tdc;
   logic [PW-1:0] s_panel;
   logic [GW-1:0] s_tag;
   logic [OW-1:0] s_order, s_age;
   logic          s_used, s_match, s_take;

   logic          wr_en;
   logic [AW-1:0] wr_addr;
   logic          push_ok, room;

   pgek_ram #(.WIDTH(DW), .DEPTH(STORE_SLOTS)) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data ({tdc_ff, panel_ff, tag_ff, arrival_ff}),
      .rd_en   (cmd.rd_en),
      .rd_addr (scan_addr),
      .rd_data (rd_data)
   );

   assign {s_tdc, s_panel, s_tag, s_order} = rd_data;
   assign s_age   = arrival_ff - s_order;
   assign s_used  = used_ff[rd_idx_ff];
   assign s_match = s_used && (pop_ff || s_panel == panel_ff);

   // push keeps the latest of the panel, pop the earliest overall
   always_comb begin
      if (!have_best_ff) begin
         s_take = 1'b1;
      end else if (pop_ff) begin
         s_take = (s_tdc < best_tdc_ff) || (s_tdc == best_tdc_ff && s_age > best_age_ff);
      end else begin
         s_take = (s_tdc > best_tdc_ff) || (s_tdc == best_tdc_ff && s_age < best_age_ff);
      end
   end

   assign push_ok = ({24'd0, panel_ff} < 32'(PANEL_COUNT)) && (keep_ff != '0);
   assign room    = 32'(count_ff) < 32'(keep_ff);

   always_comb begin
      wr_en   = 1'b0;
      wr_addr = free_ff;
      if (cmd.finish_push && push_ok) begin
         if (room) begin
            wr_en = have_free_ff;
         end else if (have_best_ff && tdc_ff < best_tdc_ff) begin
            wr_en   = 1'b1;
            wr_addr = best_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         keep_ff      <= pgek_pkg::KEEP_RESET;
         arrival_ff   <= '0;
         overflow_ff  <= 1'b0;
         used_ff      <= '0;
         rd_vld_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            keep_ff <= csr_wr_data;
         end
         rd_vld_ff <= cmd.rd_en;
         if (cmd.do_clear) begin
            used_ff     <= '0;
            arrival_ff  <= '0;
            overflow_ff <= 1'b0;
         end
         if (wr_en) begin
            used_ff[wr_addr] <= 1'b1;
            arrival_ff       <= arrival_ff + 1'b1;
         end
         if (cmd.finish_push && push_ok && room && !have_free_ff) begin
            overflow_ff <= 1'b1;
         end
         if (cmd.finish_pop) begin
            rsp_valid_ff <= 1'b1;
            if (have_best_ff) begin
               used_ff[best_ff] <= 1'b0;
            end
         end else if (rsp_valid_ff && rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      rd_idx_ff <= scan_addr;
      if (cmd.start) begin
         panel_ff     <= req_panel_id;
         tdc_ff       <= req_tdc;
         tag_ff       <= req_hit_index;
         pop_ff       <= req_is_pop;
         have_free_ff <= 1'b0;
         have_best_ff <= 1'b0;
         count_ff     <= '0;
         free_ff      <= '0;
         best_ff      <= '0;
      end else if (rd_vld_ff) begin
         if (!s_used && !have_free_ff) begin
            have_free_ff <= 1'b1;
            free_ff      <= rd_idx_ff;
         end
         if (s_match) begin
            count_ff <= count_ff + 1'b1;
            if (s_take) begin
               have_best_ff  <= 1'b1;
               best_ff       <= rd_idx_ff;
               best_tdc_ff   <= s_tdc;
               best_age_ff   <= s_age;
               best_panel_ff <= s_panel;
               best_tag_ff   <= s_tag;
            end
         end
      end
      if (cmd.finish_pop) begin
         rsp_valid_res_ff  <= have_best_ff;
         rsp_panel_ff      <= have_best_ff ? best_panel_ff : '0;
         rsp_tdc_ff        <= have_best_ff ? best_tdc_ff : '0;
         rsp_index_ff      <= have_best_ff ? best_tag_ff : '0;
         rsp_last_ff       <= have_best_ff && (count_ff == CW'(1));
         rsp_overflowed_ff <= overflow_ff;
      end
   end

   assign status.rsp_busy = rsp_valid_ff && !rsp_ready;
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_valid_res   = rsp_valid_res_ff;
   assign rsp_out_panel   = rsp_panel_ff;
   assign rsp_out_tdc     = rsp_tdc_ff;
   assign rsp_out_index   = rsp_index_ff;
   assign rsp_last        = rsp_last_ff;
   assign rsp_overflowed  = rsp_overflowed_ff;

endmodule

/* rtl/per_group_earliest_k_buffer_unit.sv */
// Per-panel earliest-k hit buffer: push hits, pop them earliest first, clear.
// The request channel (req_*) carries an action and a hit; a pop yields one
// result on the rsp_* channel, push and clear yield none.
// csr_wr_en/csr_wr_data write keep_per_panel (reset 16); the user writes it only
// while idle, which the block itself does not enforce. A push or pop reads every
// slot of the slot RAM once through its single read port; a clear needs no scan.
// req_ready is high only between requests.
// The pop result sits in an output register; if the receiver stalls, the next
// request may still be taken, and a following pop waits at its last step until
// the earlier result has been taken.
// Reset (synchronous, active high) empties the store, clears the overflow flag
// and the arrival counter and sets keep_per_panel to 16. Slot contents are not
// cleared; only the used bits gate them.
// Depends on pgek_pkg, pgek_ctrl, pgek_datapath, pgek_ram.
module per_group_earliest_k_buffer_unit #(
   parameter int STORE_SLOTS = pgek_pkg::STORE_SLOTS_DEF,
   parameter int PANEL_COUNT = pgek_pkg::PANEL_COUNT_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic [1:0]                   req_action,
   input  logic [pgek_pkg::PANEL_W-1:0] req_panel_id,
   input  logic [pgek_pkg::TDC_W-1:0]   req_tdc,
   input  logic [pgek_pkg::TAG_W-1:0]   req_hit_index,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic                         rsp_valid_res,
   output logic [pgek_pkg::PANEL_W-1:0] rsp_out_panel,
   output logic [pgek_pkg::TDC_W-1:0]   rsp_out_tdc,
   output logic [pgek_pkg::TAG_W-1:0]   rsp_out_index,
   output logic                         rsp_last,
   output logic                         rsp_overflowed,
   input  logic                         csr_wr_en,
   input  logic [pgek_pkg::KEEP_W-1:0]  csr_wr_data
);

   pgek_pkg::cmd_type              cmd;
   pgek_pkg::status_type           status;
   logic [$clog2(STORE_SLOTS)-1:0] scan_addr;

   pgek_ctrl #(.STORE_SLOTS(STORE_SLOTS)) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_action (req_action),
      .status     (status),
      .cmd        (cmd),
      .scan_addr  (scan_addr)
   );

   pgek_datapath #(.STORE_SLOTS(STORE_SLOTS), .PANEL_COUNT(PANEL_COUNT)) u_dp (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .status         (status),
      .scan_addr      (scan_addr),
      .req_panel_id   (req_panel_id),
      .req_tdc        (req_tdc),
      .req_hit_index  (req_hit_index),
      .req_is_pop     (req_action == pgek_pkg::ACT_POP),
      .csr_wr_en      (csr_wr_en),
      .csr_wr_data    (csr_wr_data),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_valid_res  (rsp_valid_res),
      .rsp_out_panel  (rsp_out_panel),
      .rsp_out_tdc    (rsp_out_tdc),
      .rsp_out_index  (rsp_out_index),
      .rsp_last       (rsp_last),
      .rsp_overflowed (rsp_overflowed)
   );

endmodule

/* verif/tb_per_group_earliest_k_buffer_unit.sv */
// Testbench for per_group_earliest_k_buffer_unit: directed and random requests,
// results checked against an in-bench model of the per-panel earliest-k store.
// Depends on pgek_pkg and the RTL of the block.
module tb_per_group_earliest_k_buffer_unit;
   import pgek_pkg::*;

   localparam int NSLOT = STORE_SLOTS_DEF;
   localparam logic [1:0] ACT_UNUSED = 2'd3;

   typedef struct {
      logic             valid_res;
      logic [PANEL_W-1:0] panel;
      logic [TDC_W-1:0] tdc;
      logic [TAG_W-1:0] tag;
      logic             last;
      logic             ovf;
   } hit_rsp_t;

   logic clock = 0;
   logic reset = 1;
   logic req_valid = 0, req_ready;
   logic [1:0] req_action = ACT_PUSH;
   logic [PANEL_W-1:0] req_panel_id = '0;
   logic [TDC_W-1:0] req_tdc = '0;
   logic [TAG_W-1:0] req_hit_index = '0;
   logic rsp_valid, rsp_ready = 0;
   logic rsp_valid_res, rsp_last, rsp_overflowed;
   logic [PANEL_W-1:0] rsp_out_panel;
   logic [TDC_W-1:0] rsp_out_tdc;
   logic [TAG_W-1:0] rsp_out_index;
   logic csr_wr_en = 0;
   logic [KEEP_W-1:0] csr_wr_data = '0;

   per_group_earliest_k_buffer_unit uut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_action(req_action),
      .req_panel_id(req_panel_id), .req_tdc(req_tdc), .req_hit_index(req_hit_index),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_valid_res(rsp_valid_res),
      .rsp_out_panel(rsp_out_panel), .rsp_out_tdc(rsp_out_tdc),
      .rsp_out_index(rsp_out_index), .rsp_last(rsp_last),
      .rsp_overflowed(rsp_overflowed),
      .csr_wr_en(csr_wr_en), .csr_wr_data(csr_wr_data)
   );

   always #6 clock = ~clock;

   // model of the hit store
   bit [TDC_W-1:0]   kept_tdc[NSLOT];
   bit [PANEL_W-1:0] kept_panel[NSLOT];
   bit [TAG_W-1:0]   kept_tag[NSLOT];
   bit [ORDER_W-1:0] kept_order[NSLOT];
   bit               kept_used[NSLOT];
   bit [ORDER_W-1:0] arrivals;
   bit               dropped_flag;
   bit [KEEP_W-1:0]  keep_limit;

   hit_rsp_t pending_hits[$];
   int errors = 0;
   int send_idle = 11, recv_idle = 49;
   bit recv_hold = 0;

   function automatic bit hit_is_later(int a, int b);
      bit [ORDER_W-1:0] age_a, age_b;
      age_a = arrivals - kept_order[a];
      age_b = arrivals - kept_order[b];
      if (kept_tdc[a] != kept_tdc[b]) return kept_tdc[a] > kept_tdc[b];
      return age_a < age_b;
   endfunction

   function automatic void store_hit(int i, bit [7:0] p, bit [15:0] t, bit [15:0] g);
      kept_tdc[i] = t; kept_panel[i] = p; kept_tag[i] = g;
      kept_order[i] = arrivals; kept_used[i] = 1; arrivals++;
   endfunction

   function automatic void predict_request(bit [1:0] act, bit [7:0] p, bit [15:0] t,
                                           bit [15:0] g);
      int cnt, free_i, latest, best;
      hit_rsp_t r;
      cnt = 0; free_i = -1; latest = -1; best = -1;
      case (act)
         ACT_PUSH: begin
            if (keep_limit == 0) return;
            for (int i = 0; i < NSLOT; i++) begin
               if (!kept_used[i]) begin
                  if (free_i < 0) free_i = i;
               end else if (kept_panel[i] == p) begin
                  cnt++;
                  if (latest < 0 || hit_is_later(i, latest)) latest = i;
               end
            end
            if (cnt < keep_limit) begin
               if (free_i >= 0) store_hit(free_i, p, t, g);
               else dropped_flag = 1;
            end else if (latest >= 0 && t < kept_tdc[latest]) begin
               store_hit(latest, p, t, g);
            end
         end
         ACT_CLEAR: begin
            foreach (kept_used[i]) kept_used[i] = 0;
            arrivals = 0; dropped_flag = 0;
         end
         ACT_POP: begin
            r = '{default: 0};
            r.ovf = dropped_flag;
            for (int i = 0; i < NSLOT; i++) begin
               if (!kept_used[i]) continue;
               cnt++;
               if (best < 0 || hit_is_later(best, i)) best = i;
            end
            if (best >= 0) begin
               r.valid_res = 1; r.panel = kept_panel[best]; r.tdc = kept_tdc[best];
               r.tag = kept_tag[best]; r.last = (cnt == 1); kept_used[best] = 0;
            end
            pending_hits.push_back(r);
         end
         default: ;
      endcase
   endfunction

   task automatic send_req(bit [1:0] act, bit [7:0] p = 0, bit [15:0] t = 0,
                           bit [15:0] g = 0);
      while ($urandom_range(99) < send_idle) begin
         req_valid = 0;
         @(negedge clock);
      end
      req_valid = 1; req_action = act; req_panel_id = p; req_tdc = t; req_hit_index = g;
      do @(posedge clock); while (!req_ready);
      predict_request(act, p, t, g);
      @(negedge clock);
      req_valid = 0;
   endtask

   // registers change only with the block idle; a push leaves no result to wait on
   task automatic write_keep(bit [KEEP_W-1:0] v);
      while (pending_hits.size() != 0) @(negedge clock);
      repeat (300) @(negedge clock);
      csr_wr_en = 1; csr_wr_data = v;
      @(negedge clock);
      csr_wr_en = 0;
      keep_limit = v;
   endtask

   task automatic drain_store();
      bit more;
      more = 1;
      while (more) begin
         more = 0;
         foreach (kept_used[i]) if (kept_used[i]) more = 1;
         send_req(ACT_POP);
      end
   endtask

   always @(negedge clock)
      rsp_ready <= !recv_hold && ($urandom_range(99) >= recv_idle);

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         hit_rsp_t e;
         if (pending_hits.size() == 0) begin
            errors++;
            if (errors <= 10) $display("unexpected result: tdc %0h", rsp_out_tdc);
         end else begin
            e = pending_hits.pop_front();
            if (rsp_valid_res !== e.valid_res || rsp_out_panel !== e.panel ||
                rsp_out_tdc !== e.tdc || rsp_out_index !== e.tag ||
                rsp_last !== e.last || rsp_overflowed !== e.ovf) begin
               errors++;
               if (errors <= 10)
                  $display("mismatch: exp v%0b p%0h t%0h i%0h l%0b o%0b got v%0b p%0h t%0h i%0h l%0b o%0b",
                     e.valid_res, e.panel, e.tdc, e.tag, e.last, e.ovf, rsp_valid_res,
                     rsp_out_panel, rsp_out_tdc, rsp_out_index, rsp_last, rsp_overflowed);
            end
         end
      end
   end

   task automatic test_directed();
      send_req(ACT_POP);                       // empty store
      send_req(ACT_UNUSED, 8'hFF, 16'hFFFF, 16'hFFFF);
      write_keep(2);
      send_req(ACT_PUSH, 8'hFF, 16'hFFFF, 16'hFFFF);
      send_req(ACT_PUSH, 8'hFF, 16'h0000, 16'h0000);
      send_req(ACT_PUSH, 8'hFF, 16'h8000, 16'h1234);   // replaces the latest
      send_req(ACT_PUSH, 8'hFF, 16'h8000, 16'h4321);   // equal, not earlier
      send_req(ACT_PUSH, 8'h00, 16'h0010, 16'hAAAA);   // tie on time: arrival order
      send_req(ACT_PUSH, 8'h00, 16'h0010, 16'h5555);
      send_req(ACT_PUSH, 8'h00, 16'h0010, 16'h0F0F);
      drain_store();
      send_req(ACT_PUSH, 8'h5A, 16'h0100, 16'h0001);
      send_req(ACT_CLEAR);
      send_req(ACT_POP);
      write_keep(0);                           // every hit dropped
      send_req(ACT_PUSH, 8'h12, 16'h0042, 16'h0042);
      send_req(ACT_POP);
   endtask

   // spread over many panels so the store runs out of slots
   task automatic test_overflow();
      write_keep(256);
      for (int i = 0; i <= NSLOT; i++)
         send_req(ACT_PUSH, 8'(i), 16'($urandom), 16'($urandom));
      send_req(ACT_POP);
      send_req(ACT_POP);
      send_req(ACT_CLEAR);
      send_req(ACT_POP);
   endtask

   task automatic test_backpressure();
      write_keep(16);
      repeat (6) send_req(ACT_PUSH, 8'($urandom_range(3)), 16'($urandom), 16'($urandom));
      fork
         begin
            recv_hold = 1;
            repeat (3000) @(negedge clock);
            recv_hold = 0;
         end
      join_none
      repeat (7) send_req(ACT_POP);
   endtask

   task automatic test_random(int n_items);
      int sent, nhits, npanels;
      sent = 0;
      while (sent < n_items) begin
         if ($urandom_range(9) == 0) write_keep(9'($urandom_range(1, 40)));
         if ($urandom_range(4) == 0) begin
            // noise
            send_req(2'($urandom), 8'($urandom), 16'($urandom), 16'($urandom));
            sent++;
         end else begin
            nhits = $urandom_range(1, 12);
            npanels = $urandom_range(1, 4);
            for (int i = 0; i < nhits; i++)
               send_req(ACT_PUSH,
                        ($urandom_range(3) == 0) ? 8'($urandom) : 8'($urandom_range(npanels)),
                        ($urandom_range(2) == 0) ? 16'($urandom_range(7)) : 16'($urandom),
                        16'($urandom));
            sent += nhits;
            if ($urandom_range(5) == 0) begin
               send_req(ACT_CLEAR);
            end else begin
               drain_store();
               send_req(ACT_POP);
            end
            sent += 2;
         end
      end
   endtask

   initial begin
      keep_limit = KEEP_RESET;
      arrivals = 0; dropped_flag = 0;
      foreach (kept_used[i]) kept_used[i] = 0;
      repeat (5) @(negedge clock);
      reset = 0;
      test_directed();
      test_overflow();
      test_backpressure();
      test_random(400);
      send_idle = 49; recv_idle = 11;
      test_random(400);
      send_idle = 0; recv_idle = 0;
      test_random(400);
      while (pending_hits.size() != 0) @(negedge clock);
      repeat (300) @(negedge clock);
      if (errors == 0) $display("DONE: 0 errors");
      else $display("DONE: errors detected");
      $finish;
   end

   initial begin
      #(12 * 4000000);
      $display("DONE: errors detected");
      $finish;
   end

endmodule
